// ----- rtl/core/cpsm_pkg.sv -----
// shared constants and types for the capture period speed meter
`timescale 1ns / 1ps

package cpsm_pkg;

  localparam int RING_SLOTS = 13;
  localparam int TIMER_BITS = 24;
  localparam int SLOT_W     = $clog2(RING_SLOTS);
  localparam int DATA_W     = 32;
  localparam int ALU_W      = DATA_W + 2;
  localparam int EXT_W      = 7;
  localparam int CNT_W      = $clog2(DATA_W);
  localparam int CAP_W      = 24;

  localparam logic [EXT_W-1:0]  UNIT_MAX    = {EXT_W{1'b1}};
  localparam logic [ALU_W-1:0]  TIMER_UNIT  = ALU_W'(64'd1 << TIMER_BITS);
  localparam logic [DATA_W-1:0] SCALE_RESET = 32'd3000000000;
  localparam logic [EXT_W-1:0]  TMO_RESET   = 7'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_UNITS = 1'd1;

  typedef struct packed {
    logic              clr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
  } ring_ctl_t;

endpackage

// ----- rtl/core/cpsm_alu.sv -----
// shared add / subtract unit, borrow shows in the top bit
`timescale 1ns / 1ps

module cpsm_alu (
  input  logic [cpsm_pkg::ALU_W-1:0] a,
  input  logic [cpsm_pkg::ALU_W-1:0] b,
  input  logic                       sub,
  output logic [cpsm_pkg::ALU_W-1:0] res
);

  logic [cpsm_pkg::ALU_W-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign res   = a + b_eff + cpsm_pkg::ALU_W'(sub);

endmodule

// ----- rtl/core/cpsm_ring.sv -----
// period ring: one write and one read slot per cycle, cleared as a whole
`timescale 1ns / 1ps

module cpsm_ring (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cpsm_pkg::ring_ctl_t         ctl,
  input  logic [cpsm_pkg::DATA_W-1:0] wr_data,
  output logic [cpsm_pkg::DATA_W-1:0] rd_data
);

  logic [cpsm_pkg::DATA_W-1:0] ring_r [cpsm_pkg::RING_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int i = 0; i < cpsm_pkg::RING_SLOTS; i++) begin
        ring_r[i] <= '0;
      end
    end else if (ctl.wr_en) begin
      ring_r[ctl.wr_slot] <= wr_data;
    end
  end

  assign rd_data = ring_r[ctl.rd_slot];

endmodule

// ----- rtl/core/capture_period_speed_meter.sv -----
// top level: sequencer around one shared add / subtract unit and the period ring
//
//   channel | dir | group                          | contents
//   in_     | in  | tvalid tready tdata tuser      | capture value; wrap and capture flags
//   out_    | out | tvalid tready tdata tuser      | period sum, speed; window full flag
//   cfg_    | in  | we index wdata                 | speed scale, timeout units
//
// out_tvalid rises after the accepting edge once these steps have run in order:
// wrap, race fix, period, fold compare, fold subtract, ring add, ring drop,
// divide setup, the radix-2 divide that shares the adder, and output; capture
// steps are skipped without a capture, and the divide is skipped while the
// window is not full or the sum is zero.
// in_tready is high only in idle; a result waits in the output register and the
// next beat may be taken meanwhile. rst_n is synchronous and clears the ring.
`timescale 1ns / 1ps

module capture_period_speed_meter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,   // capture_value
  input  logic [1:0]                        in_tuser,   // overflow_event, capture_event
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata,  // period_sum, speed_rpm
  output logic [0:0]                        out_tuser,  // window_full
  input  logic                              cfg_we,
  input  logic [cpsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cpsm_pkg::DATA_W-1:0]       cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_RACE, S_PER, S_FCMP, S_FSUB, S_ADD, S_SUB, S_DSET, S_DIV, S_DONE
  } state_t;

  localparam int DW = cpsm_pkg::DATA_W;
  localparam int AW = cpsm_pkg::ALU_W;
  localparam int EW = cpsm_pkg::EXT_W;
  localparam int SW = cpsm_pkg::SLOT_W;
  localparam int TB = cpsm_pkg::TIMER_BITS;

  state_t            state_r, state_nxt;
  logic [DW-1:0]     scale_r;
  logic [EW-1:0]     tmo_r;
  logic              ovf_r, ovf_nxt;
  logic              cev_r, cev_nxt;
  logic [TB-1:0]     cap_r, cap_nxt;
  logic [EW-1:0]     ext_r, ext_nxt;
  logic [TB-1:0]     prev_r, prev_nxt;
  logic              race_r, race_nxt;
  logic [SW-1:0]     slot_r, slot_nxt;
  logic [DW-1:0]     sum_r, sum_nxt;
  logic              full_r, full_nxt;
  logic [DW-1:0]     per_r, per_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [DW-1:0]     quo_r, quo_nxt;
  logic [cpsm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [63:0]       odata_r, odata_nxt;
  logic              ofull_r, ofull_nxt;

  logic [AW-1:0]     alu_a, alu_b, alu_res;
  logic              alu_sub, borrow;
  logic [EW-1:0]     ext_inc;
  logic [DW:0]       rem_sh;
  logic [DW-1:0]     ring_rd;
  logic [SW-1:0]     slot_adv;
  cpsm_pkg::ring_ctl_t ring_ctl;

  cpsm_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  cpsm_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .wr_data (per_r),
    .rd_data (ring_rd)
  );

  assign borrow   = alu_res[AW-1];
  assign rem_sh   = {rem_r, quo_r[DW-1]};
  assign slot_adv = (slot_r == SW'(cpsm_pkg::RING_SLOTS - 1)) ? '0 : slot_r + 1'b1;
  assign ext_inc  = (ext_r < cpsm_pkg::UNIT_MAX && !race_r) ? ext_r + 1'b1 : ext_r;

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    case (state_r)
      S_RACE: begin
        alu_a = AW'(cap_r);
        alu_b = AW'(prev_r);
      end
      S_PER: begin
        alu_a = AW'(DW'((DW+TB)'(ext_r) << TB) | DW'(cap_r));
        alu_b = AW'(prev_r);
      end
      S_FCMP: begin
        alu_a = cpsm_pkg::TIMER_UNIT;
        alu_b = AW'(per_r);
      end
      S_FSUB: begin
        alu_a = AW'(per_r);
        alu_b = cpsm_pkg::TIMER_UNIT;
      end
      S_ADD: begin
        alu_a   = AW'(sum_r);
        alu_b   = AW'(per_r);
        alu_sub = 1'b0;
      end
      S_SUB: begin
        alu_a = AW'(sum_r);
        alu_b = AW'(ring_rd);
      end
      S_DIV: begin
        alu_a = AW'(rem_sh);
        alu_b = AW'(sum_r);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    ovf_nxt    = ovf_r;
    cev_nxt    = cev_r;
    cap_nxt    = cap_r;
    ext_nxt    = ext_r;
    prev_nxt   = prev_r;
    race_nxt   = race_r;
    slot_nxt   = slot_r;
    sum_nxt    = sum_r;
    full_nxt   = full_r;
    per_nxt    = per_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ofull_nxt  = ofull_r;
    ring_ctl   = '{clr: 1'b0, wr_en: 1'b0, wr_slot: slot_r, rd_slot: slot_r};

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ovf_nxt   = in_tuser[0];
          cev_nxt   = in_tuser[1];
          cap_nxt   = TB'(in_tdata);
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        if (ovf_r) begin
          race_nxt = 1'b0;
          if (ext_inc > tmo_r) begin
            ring_ctl.clr = 1'b1;
            slot_nxt     = '0;
            sum_nxt      = '0;
            full_nxt     = 1'b0;
            ext_nxt      = '0;
          end else begin
            ext_nxt = ext_inc;
          end
        end
        state_nxt = cev_r ? S_RACE : S_DSET;
      end
      S_RACE: begin
        // timestamp went backwards with no wrap seen yet
        if (borrow && ext_r == '0) begin
          ext_nxt  = EW'(1);
          race_nxt = 1'b1;
        end
        state_nxt = S_PER;
      end
      S_PER: begin
        per_nxt   = alu_res[DW-1:0];
        state_nxt = S_FCMP;
      end
      S_FCMP: begin
        state_nxt = borrow ? S_FSUB : S_ADD;
      end
      S_FSUB: begin
        per_nxt   = alu_res[DW-1:0];
        state_nxt = S_ADD;
      end
      S_ADD: begin
        sum_nxt        = alu_res[DW-1:0];
        ring_ctl.wr_en = 1'b1;
        slot_nxt       = slot_adv;
        prev_nxt       = cap_r;
        ext_nxt        = '0;
        state_nxt      = S_SUB;
      end
      S_SUB: begin
        // drop the oldest period, now sitting in the new slot
        sum_nxt = alu_res[DW-1:0];
        if (slot_r == '0) begin
          full_nxt = 1'b1;
        end
        state_nxt = S_DSET;
      end
      S_DSET: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        if (full_r && sum_r != '0) begin
          quo_nxt   = scale_r;
          state_nxt = S_DIV;
        end else begin
          quo_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (!borrow) begin
          rem_nxt = alu_res[DW-1:0];
        end else begin
          rem_nxt = rem_sh[DW-1:0];
        end
        quo_nxt = {quo_r[DW-2:0], ~borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {quo_r, full_r ? sum_r : '0};
          ofull_nxt  = full_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      scale_r  <= cpsm_pkg::SCALE_RESET;
      tmo_r    <= cpsm_pkg::TMO_RESET;
      ext_r    <= '0;
      prev_r   <= '0;
      race_r   <= 1'b0;
      slot_r   <= '0;
      sum_r    <= '0;
      full_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ext_r    <= ext_nxt;
      prev_r   <= prev_nxt;
      race_r   <= race_nxt;
      slot_r   <= slot_nxt;
      sum_r    <= sum_nxt;
      full_r   <= full_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          cpsm_pkg::REG_SPEED_SCALE:   scale_r <= cfg_wdata;
          cpsm_pkg::REG_TIMEOUT_UNITS: tmo_r   <= cfg_wdata[EW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ovf_r   <= ovf_nxt;
    cev_r   <= cev_nxt;
    cap_r   <= cap_nxt;
    per_r   <= per_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
    ofull_r <= ofull_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ofull_r;

endmodule

// ----- rtl/core/cpsm_checker.sv -----
// port checker for the speed meter, bound to the top level
`timescale 1ns / 1ps

module cpsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_not_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 64'd0)
    else $error("sum or speed shown before the window is full");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is in progress");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared one cycle after the beat");

endmodule

bind capture_period_speed_meter cpsm_checker u_cpsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
